>>> rtl/chc_pkg.sv
`timescale 1ns / 1ps

package chc_pkg;

   localparam int DOUBLE_ROUNDS = 10;
   localparam int HALF_ROUNDS   = 2 * DOUBLE_ROUNDS;
   localparam int HALF_W        = $clog2(HALF_ROUNDS);

   typedef logic [31:0] word_type;
   typedef logic [15:0][31:0] state_type;

   // quarter-round line step, also selects the rotation
   typedef enum logic [1:0] {
      STEP_ROT16 = 2'd0,
      STEP_ROT12 = 2'd1,
      STEP_ROT8  = 2'd2,
      STEP_ROT7  = 2'd3
   } step_type;

   // configuration register indexes
   localparam logic [2:0] REG_KEY0    = 3'd0;
   localparam logic [2:0] REG_KEY1    = 3'd1;
   localparam logic [2:0] REG_KEY2    = 3'd2;
   localparam logic [2:0] REG_KEY3    = 3'd3;
   localparam logic [2:0] REG_NONCE_L = 3'd4;
   localparam logic [2:0] REG_NONCE_H = 3'd5;
   localparam logic [2:0] REG_CTR     = 3'd6;

   localparam word_type SIGMA0 = 32'h61707865;
   localparam word_type SIGMA1 = 32'h3320646e;
   localparam word_type SIGMA2 = 32'h79622d32;
   localparam word_type SIGMA3 = 32'h6b206574;

   // request from the control side to the block generator
   typedef struct packed {
      logic       start;
      logic [2:0] word_sel;
   } gen_ctrl_type;

   // answer from the block generator
   typedef struct packed {
      logic        done;
      logic [63:0] ks_word;
   } gen_out_type;

   // initial state words of one block
   function automatic state_type chc_init(input logic [63:0] k0, input logic [63:0] k1,
                                          input logic [63:0] k2, input logic [63:0] k3,
                                          input logic [63:0] nl, input word_type nh,
                                          input word_type ctr);
      state_type s;
      s[0]  = SIGMA0;
      s[1]  = SIGMA1;
      s[2]  = SIGMA2;
      s[3]  = SIGMA3;
      s[4]  = k0[31:0];
      s[5]  = k0[63:32];
      s[6]  = k1[31:0];
      s[7]  = k1[63:32];
      s[8]  = k2[31:0];
      s[9]  = k2[63:32];
      s[10] = k3[31:0];
      s[11] = k3[63:32];
      s[12] = ctr;
      s[13] = nl[31:0];
      s[14] = nl[63:32];
      s[15] = nh;
      return s;
   endfunction

endpackage

>>> rtl/chc_line_unit.sv
`timescale 1ns / 1ps

// one line of four quarter-rounds: p += q; r ^= p; r <<<= k
module chc_line_unit (
   input  chc_pkg::word_type p_word [4],
   input  chc_pkg::word_type q_word [4],
   input  chc_pkg::word_type r_word [4],
   input  chc_pkg::step_type step,
   output chc_pkg::word_type p_new [4],
   output chc_pkg::word_type r_new [4]
);
   import chc_pkg::*;

   word_type sum_w [4];
   word_type mix_w [4];

   for (genvar g = 0; g < 4; g++) begin : g_lane
      assign sum_w[g] = p_word[g] + q_word[g];
      assign mix_w[g] = r_word[g] ^ sum_w[g];
      assign p_new[g] = sum_w[g];

      // fixed rotations picked by step
      always_comb begin
         case (step)
            STEP_ROT16: r_new[g] = {mix_w[g][15:0], mix_w[g][31:16]};
            STEP_ROT12: r_new[g] = {mix_w[g][19:0], mix_w[g][31:20]};
            STEP_ROT8:  r_new[g] = {mix_w[g][23:0], mix_w[g][31:24]};
            STEP_ROT7:  r_new[g] = {mix_w[g][24:0], mix_w[g][31:25]};
            default:    r_new[g] = mix_w[g];
         endcase
      end
   end

endmodule

>>> rtl/chc_block_gen.sv
`timescale 1ns / 1ps

// keystream block generator: one line step of four lanes per cycle,
// then add-back; the final words stay in place as the keystream buffer
module chc_block_gen (
   input  logic                   clock,
   input  logic                   reset,
   input  chc_pkg::gen_ctrl_type  ctrl,
   input  chc_pkg::state_type     init_words,
   output chc_pkg::gen_out_type   gen_out
);
   import chc_pkg::*;

   typedef enum logic [1:0] {
      G_IDLE,
      G_ROUND,
      G_ADD
   } gen_state_type;

   gen_state_type gst_ff, gst_in;
   step_type      step_ff, step_in;
   logic [HALF_W-1:0] half_ff, half_in;
   logic          done_ff, done_in;
   state_type     st_ff, st_in;

   logic       diag;
   logic       odd;
   logic [1:0] bcol [4];
   logic [1:0] ccol [4];
   logic [1:0] dcol [4];
   word_type   p_w [4];
   word_type   q_w [4];
   word_type   r_w [4];
   word_type   p_new [4];
   word_type   r_new [4];

   assign diag = half_ff[0];
   assign odd  = step_ff[0];

   // lane gather: columns, or diagonals on odd half rounds
   for (genvar g = 0; g < 4; g++) begin : g_gather
      assign bcol[g] = 2'(g) + (diag ? 2'd1 : 2'd0);
      assign ccol[g] = 2'(g) + (diag ? 2'd2 : 2'd0);
      assign dcol[g] = 2'(g) + (diag ? 2'd3 : 2'd0);
      assign p_w[g]  = odd ? st_ff[{2'd2, ccol[g]}] : st_ff[{2'd0, 2'(g)}];
      assign q_w[g]  = odd ? st_ff[{2'd3, dcol[g]}] : st_ff[{2'd1, bcol[g]}];
      assign r_w[g]  = odd ? st_ff[{2'd1, bcol[g]}] : st_ff[{2'd3, dcol[g]}];
   end

   chc_line_unit u_line (
      .p_word (p_w),
      .q_word (q_w),
      .r_word (r_w),
      .step   (step_ff),
      .p_new  (p_new),
      .r_new  (r_new)
   );

   // sequencer and state update
   always_comb begin
      gst_in  = gst_ff;
      step_in = step_ff;
      half_in = half_ff;
      done_in = 1'b0;
      st_in   = st_ff;
      case (gst_ff)
         G_IDLE: begin
            if (ctrl.start) begin
               st_in   = init_words;
               step_in = STEP_ROT16;
               half_in = '0;
               gst_in  = G_ROUND;
            end
         end
         G_ROUND: begin
            for (int i = 0; i < 4; i++) begin
               if (odd) begin
                  st_in[{2'd2, ccol[i]}] = p_new[i];
                  st_in[{2'd1, bcol[i]}] = r_new[i];
               end else begin
                  st_in[{2'd0, 2'(i)}]   = p_new[i];
                  st_in[{2'd3, dcol[i]}] = r_new[i];
               end
            end
            step_in = step_type'(step_ff + 2'd1);
            if (step_ff == STEP_ROT7) begin
               half_in = half_ff + 1'b1;
               if (half_ff == HALF_W'(HALF_ROUNDS - 1)) begin
                  gst_in = G_ADD;
               end
            end
         end
         G_ADD: begin
            for (int i = 0; i < 16; i++) begin
               st_in[4'(i)] = st_ff[4'(i)] + init_words[4'(i)];
            end
            done_in = 1'b1;
            gst_in  = G_IDLE;
         end
         default: gst_in = G_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         gst_ff  <= G_IDLE;
         done_ff <= 1'b0;
      end else begin
         gst_ff  <= gst_in;
         done_ff <= done_in;
      end
      step_ff <= step_in;
      half_ff <= half_in;
      st_ff   <= st_in;
   end

   assign gen_out.done    = done_ff;
   assign gen_out.ks_word = {st_ff[{ctrl.word_sel, 1'b1}], st_ff[{ctrl.word_sel, 1'b0}]};

endmodule

>>> rtl/chacha20_stream_xor.sv
`timescale 1ns / 1ps

// ChaCha20 stream XOR, eight message bytes per item.
// Load key, nonce and initial counter through the csr_ write port while idle.
// Items enter on req_ (valid/stall) and results leave on rsp_ (valid/stall),
// one result per item, in order. req_last_in ends a message; the next item
// restarts at the configured counter and keystream offset zero.
// Each 64-byte keystream block serves eight items. An item that needs a new
// block waits for the block generator: load plus 4 line steps per half round
// over 2*DOUBLE_ROUNDS half rounds plus add-back, then the done handoff and
// the result register, which raises rsp_valid once the output is free.
// The other seven items of a block go out in the cycle after accept and can be
// taken one per cycle while rsp_stall stays low; block generation on the
// single shared line unit sets the pace of a full message.
// The result register takes a new item while the previous one is being taken;
// if rsp_stall holds a result, req_stall rises and the result stays put.
// Reset clears the configuration to zero and ends any message in progress.
module chacha20_stream_xor (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_we,
   input  logic [2:0]  csr_index,
   input  logic [63:0] csr_wdata,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [63:0] req_data_in,
   input  logic [3:0]  req_byte_count,
   input  logic        req_last_in,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [63:0] rsp_data_out,
   output logic [3:0]  rsp_byte_count_out,
   output logic        rsp_last_out
);
   import chc_pkg::*;

   typedef enum logic [1:0] {
      T_IDLE,
      T_GEN,
      T_EMIT
   } top_state_type;

   // configuration registers
   logic [63:0] key0_ff, key1_ff, key2_ff, key3_ff, nonce_l_ff;
   word_type    nonce_h_ff, init_ctr_ff;

   top_state_type tst_ff, tst_in;
   logic        active_ff, active_in;
   logic [2:0]  offset_ff, offset_in;
   word_type    counter_ff, counter_in;
   logic [63:0] hold_data_ff, hold_data_in;
   logic [3:0]  hold_count_ff, hold_count_in;
   logic        hold_last_ff, hold_last_in;
   logic        rsp_valid_ff, rsp_valid_in;
   logic [63:0] rsp_data_ff, rsp_data_in;
   logic [3:0]  rsp_count_ff, rsp_count_in;
   logic        rsp_last_ff, rsp_last_in;

   logic         out_free;
   logic         accept;
   logic         need_blk;
   word_type     ctr_start;
   word_type     init_ctr_sel;
   state_type    init_words;
   gen_ctrl_type gen_ctrl;
   gen_out_type  gen_out;

   // byte mask from a count, counts of eight and up keep all bytes
   function automatic logic [63:0] byte_mask(input logic [3:0] cnt);
      logic [63:0] m;
      for (int i = 0; i < 8; i++) begin
         m[8*i +: 8] = (cnt > 4'(i)) ? 8'hff : 8'h00;
      end
      return m;
   endfunction

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         key0_ff     <= '0;
         key1_ff     <= '0;
         key2_ff     <= '0;
         key3_ff     <= '0;
         nonce_l_ff  <= '0;
         nonce_h_ff  <= '0;
         init_ctr_ff <= '0;
      end else if (csr_we) begin
         case (csr_index)
            REG_KEY0:    key0_ff     <= csr_wdata;
            REG_KEY1:    key1_ff     <= csr_wdata;
            REG_KEY2:    key2_ff     <= csr_wdata;
            REG_KEY3:    key3_ff     <= csr_wdata;
            REG_NONCE_L: nonce_l_ff  <= csr_wdata;
            REG_NONCE_H: nonce_h_ff  <= csr_wdata[31:0];
            REG_CTR:     init_ctr_ff <= csr_wdata[31:0];
            default: ;
         endcase
      end
   end

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign req_stall = !((tst_ff == T_IDLE) && out_free);
   assign accept    = req_valid && !req_stall;
   assign need_blk  = !active_ff || (offset_ff == 3'd0);
   assign ctr_start = active_ff ? counter_ff : init_ctr_ff;

   // block counter seen by the generator at start and at add-back
   assign init_ctr_sel = (tst_ff == T_IDLE) ? ctr_start : counter_ff;
   assign init_words   = chc_init(key0_ff, key1_ff, key2_ff, key3_ff,
                                  nonce_l_ff, nonce_h_ff, init_ctr_sel);

   chc_block_gen u_gen (
      .clock      (clock),
      .reset      (reset),
      .ctrl       (gen_ctrl),
      .init_words (init_words),
      .gen_out    (gen_out)
   );

   // item control
   always_comb begin
      tst_in        = tst_ff;
      active_in     = active_ff;
      offset_in     = offset_ff;
      counter_in    = counter_ff;
      hold_data_in  = hold_data_ff;
      hold_count_in = hold_count_ff;
      hold_last_in  = hold_last_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_data_in   = rsp_data_ff;
      rsp_count_in  = rsp_count_ff;
      rsp_last_in   = rsp_last_ff;
      gen_ctrl.start    = 1'b0;
      gen_ctrl.word_sel = offset_ff;
      case (tst_ff)
         T_IDLE: begin
            if (accept) begin
               if (need_blk) begin
                  counter_in     = ctr_start;
                  offset_in      = 3'd0;
                  active_in      = 1'b1;
                  hold_data_in   = req_data_in;
                  hold_count_in  = req_byte_count;
                  hold_last_in   = req_last_in;
                  gen_ctrl.start = 1'b1;
                  tst_in         = T_GEN;
               end else begin
                  rsp_valid_in = 1'b1;
                  rsp_data_in  = (req_data_in ^ gen_out.ks_word) & byte_mask(req_byte_count);
                  rsp_count_in = req_byte_count;
                  rsp_last_in  = req_last_in;
                  offset_in    = offset_ff + 3'd1;
                  active_in    = !req_last_in;
               end
            end
         end
         T_GEN: begin
            if (gen_out.done) begin
               counter_in = counter_ff + 32'd1;
               tst_in     = T_EMIT;
            end
         end
         T_EMIT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = (hold_data_ff ^ gen_out.ks_word) & byte_mask(hold_count_ff);
               rsp_count_in = hold_count_ff;
               rsp_last_in  = hold_last_ff;
               offset_in    = offset_ff + 3'd1;
               active_in    = !hold_last_ff;
               tst_in       = T_IDLE;
            end
         end
         default: tst_in = T_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tst_ff       <= T_IDLE;
         active_ff    <= 1'b0;
         offset_ff    <= 3'd0;
         counter_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         tst_ff       <= tst_in;
         active_ff    <= active_in;
         offset_ff    <= offset_in;
         counter_ff   <= counter_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      hold_data_ff  <= hold_data_in;
      hold_count_ff <= hold_count_in;
      hold_last_ff  <= hold_last_in;
      rsp_data_ff   <= rsp_data_in;
      rsp_count_ff  <= rsp_count_in;
      rsp_last_ff   <= rsp_last_in;
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_data_out       = rsp_data_ff;
   assign rsp_byte_count_out = rsp_count_ff;
   assign rsp_last_out       = rsp_last_ff;

endmodule

>>> test/tb_chacha20_stream_xor.sv
`timescale 1ns / 1ps

module tb_chacha20_stream_xor;
   import chc_pkg::*;

   localparam logic [2:0] REG_UNUSED = 3'd7;
   localparam int QUIET_LIMIT = 4000;

   // one item on either channel
   typedef struct packed {
      logic [63:0] data;
      logic [3:0]  count;
      logic        last;
   } cipher_item_type;

   // keystream predictor and in-order store of predicted ciphertext
   class keystream_scoreboard;
      logic [63:0]     key [4];
      logic [63:0]     nonce_lo;
      word_type        nonce_hi;
      word_type        ctr_init;
      logic [63:0]     ks_words [8];
      logic [2:0]      word_pos;
      word_type        blk_ctr;
      bit              in_msg;
      word_type        work [16];
      cipher_item_type cipher_q [$];
      int              errors;

      function new();
         foreach (key[i]) key[i] = '0;
         nonce_lo = '0;
         nonce_hi = '0;
         ctr_init = '0;
         word_pos = '0;
         blk_ctr  = '0;
         in_msg   = 1'b0;
         errors   = 0;
      endfunction

      function void write_reg(logic [2:0] idx, logic [63:0] value);
         case (idx)
            REG_KEY0:    key[0] = value;
            REG_KEY1:    key[1] = value;
            REG_KEY2:    key[2] = value;
            REG_KEY3:    key[3] = value;
            REG_NONCE_L: nonce_lo = value;
            REG_NONCE_H: nonce_hi = value[31:0];
            REG_CTR:     ctr_init = value[31:0];
            default: ;
         endcase
      endfunction

      function word_type rotl(word_type v, int n);
         return (v << n) | (v >> (32 - n));
      endfunction

      function void quarter_round(int a, int b, int c, int d);
         work[a] += work[b]; work[d] = rotl(work[d] ^ work[a], 16);
         work[c] += work[d]; work[b] = rotl(work[b] ^ work[c], 12);
         work[a] += work[b]; work[d] = rotl(work[d] ^ work[a], 8);
         work[c] += work[d]; work[b] = rotl(work[b] ^ work[c], 7);
      endfunction

      // 64 keystream bytes from key, counter and nonce, then counter step
      function void make_keystream_block();
         word_type seed [16];
         seed[0] = SIGMA0;
         seed[1] = SIGMA1;
         seed[2] = SIGMA2;
         seed[3] = SIGMA3;
         for (int i = 0; i < 4; i++) begin
            seed[4 + 2 * i] = key[i][31:0];
            seed[5 + 2 * i] = key[i][63:32];
         end
         seed[12] = blk_ctr;
         seed[13] = nonce_lo[31:0];
         seed[14] = nonce_lo[63:32];
         seed[15] = nonce_hi;
         work = seed;
         for (int r = 0; r < DOUBLE_ROUNDS; r++) begin
            // column round
            quarter_round(0, 4, 8, 12);
            quarter_round(1, 5, 9, 13);
            quarter_round(2, 6, 10, 14);
            quarter_round(3, 7, 11, 15);
            // diagonal round
            quarter_round(0, 5, 10, 15);
            quarter_round(1, 6, 11, 12);
            quarter_round(2, 7, 8, 13);
            quarter_round(3, 4, 9, 14);
         end
         for (int i = 0; i < 16; i++) work[i] += seed[i];
         for (int i = 0; i < 8; i++) ks_words[i] = {work[2 * i + 1], work[2 * i]};
         blk_ctr += 32'd1;
      endfunction

      // accepted plaintext item: predict its ciphertext
      function void note_plaintext(cipher_item_type item);
         cipher_item_type want;
         logic [63:0]     mask;
         if (!in_msg) begin
            blk_ctr  = ctr_init;
            word_pos = '0;
            in_msg   = 1'b1;
         end
         if (word_pos == 3'd0) make_keystream_block();
         // counts above eight act as eight, zero keeps no byte
         mask = (item.count >= 4'd8) ? '1 : (64'd1 << (8 * item.count)) - 64'd1;
         want.data  = (item.data ^ ks_words[word_pos]) & mask;
         want.count = item.count;
         want.last  = item.last;
         cipher_q.push_back(want);
         word_pos = word_pos + 3'd1;
         if (item.last) in_msg = 1'b0;
      endfunction

      // accepted result item: compare with the oldest prediction
      function void check_ciphertext(cipher_item_type got);
         cipher_item_type want;
         if (cipher_q.size() == 0) begin
            $display("%0t: unexpected result, actual data %h count %0d last %0b",
                     $time, got.data, got.count, got.last);
            errors++;
            return;
         end
         want = cipher_q.pop_front();
         if (got !== want) begin
            $display("%0t: mismatch, expected data %h count %0d last %0b",
                     $time, want.data, want.count, want.last,
                     ", actual data %h count %0d last %0b",
                     got.data, got.count, got.last);
            errors++;
         end
      endfunction
   endclass

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        csr_we;
   logic [2:0]  csr_index;
   logic [63:0] csr_wdata;
   logic        req_valid;
   logic        req_stall;
   logic [63:0] req_data_in;
   logic [3:0]  req_byte_count;
   logic        req_last_in;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [63:0] rsp_data_out;
   logic [3:0]  rsp_byte_count_out;
   logic        rsp_last_out;

   keystream_scoreboard sb = new();
   int idle_pct = 10;
   int left_in_msg = 0;
   int quiet_cycles = 0;

   chacha20_stream_xor u_dut (
      .clock              (clock),
      .reset              (reset),
      .csr_we             (csr_we),
      .csr_index          (csr_index),
      .csr_wdata          (csr_wdata),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_data_in        (req_data_in),
      .req_byte_count     (req_byte_count),
      .req_last_in        (req_last_in),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_data_out       (rsp_data_out),
      .rsp_byte_count_out (rsp_byte_count_out),
      .rsp_last_out       (rsp_last_out)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // receiver stalls at random
   always @(posedge clock) begin
      rsp_stall <= ($urandom_range(0, 99) < idle_pct);
   end

   // results are sampled mid-cycle, ahead of the accepting edge
   always @(negedge clock) begin
      if (!reset && rsp_valid && !rsp_stall)
         sb.check_ciphertext({rsp_data_out, rsp_byte_count_out, rsp_last_out});
   end

   // watchdog on cycles with no item moving on either channel
   always @(negedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end
   end

   function automatic logic [63:0] rand64();
      return {$urandom, $urandom};
   endfunction

   function automatic logic [63:0] pick_word();
      case ($urandom_range(0, 5))
         0: return '0;
         1: return '1;
         default: return rand64();
      endcase
   endfunction

   function automatic logic [31:0] pick_counter();
      case ($urandom_range(0, 4))
         0: return '0;
         1: return '1;
         2: return 32'hffff_ffff - $urandom_range(0, 3);
         default: return $urandom;
      endcase
   endfunction

   task automatic write_reg(logic [2:0] idx, logic [63:0] value);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      sb.write_reg(idx, value);
   endtask

   // full register set, plus a write to an unmapped index
   task automatic load_setting(logic [63:0] k0, logic [63:0] k1, logic [63:0] k2,
                               logic [63:0] k3, logic [63:0] nl, logic [63:0] nh,
                               logic [63:0] ctr);
      write_reg(REG_KEY0, k0);
      write_reg(REG_KEY1, k1);
      write_reg(REG_KEY2, k2);
      write_reg(REG_KEY3, k3);
      write_reg(REG_NONCE_L, nl);
      write_reg(REG_NONCE_H, nh);
      write_reg(REG_CTR, ctr);
      write_reg(REG_UNUSED, rand64());
      csr_we <= 1'b0;
   endtask

   // sender pauses until every predicted result has come back
   task automatic wait_drained();
      req_valid <= 1'b0;
      do @(posedge clock); while (sb.cipher_q.size() != 0);
   endtask

   task automatic send_item(logic [63:0] data, logic [3:0] count, logic last);
      cipher_item_type item;
      while ($urandom_range(0, 99) < idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      item = {data, count, last};
      req_valid      <= 1'b1;
      req_data_in    <= data;
      req_byte_count <= count;
      req_last_in    <= last;
      do @(negedge clock); while (req_stall);
      sb.note_plaintext(item);
      @(posedge clock);
   endtask

   // random messages, mostly full items, some odd counts
   task automatic run_items(int n);
      logic [63:0] data;
      logic [3:0]  count;
      logic        last;
      for (int i = 0; i < n; i++) begin
         if (left_in_msg == 0)
            left_in_msg = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 40)
                                                      : $urandom_range(1, 12);
         last = (left_in_msg == 1);
         left_in_msg--;
         if ($urandom_range(0, 19) == 0)
            count = $urandom_range(0, 15);
         else if (last)
            count = $urandom_range(1, 8);
         else
            count = 4'd8;
         case ($urandom_range(0, 15))
            0: data = '0;
            1: data = '1;
            default: data = rand64();
         endcase
         send_item(data, count, last);
         if ($urandom_range(0, 39) == 0) wait_drained();
      end
   endtask

   initial begin
      req_valid      <= 1'b0;
      req_data_in    <= '0;
      req_byte_count <= 4'd8;
      req_last_in    <= 1'b0;
      csr_we         <= 1'b0;
      csr_index      <= REG_KEY0;
      csr_wdata      <= '0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // all-zero key and nonce from reset: odd counts, second block
      send_item('0, 4'd8, 1'b0);
      send_item('1, 4'd8, 1'b0);
      send_item(rand64(), 4'd0, 1'b0);
      send_item(rand64(), 4'd9, 1'b0);
      send_item(rand64(), 4'd15, 1'b0);
      send_item(rand64(), 4'd3, 1'b0);
      send_item(rand64(), 4'd1, 1'b0);
      send_item(rand64(), 4'd7, 1'b0);
      send_item(rand64(), 4'd8, 1'b0);
      send_item(rand64(), 4'd5, 1'b1);
      // one-item message restarts at the initial counter
      send_item(rand64(), 4'd8, 1'b1);

      // standard test key and nonce, counter about to wrap
      wait_drained();
      load_setting(64'h0706050403020100, 64'h0f0e0d0c0b0a0908,
                   64'h1716151413121110, 64'h1f1e1d1c1b1a1918,
                   64'h4a00000000000000, {32'hdead_beef, 32'h0}, 64'hffff_ffff);
      for (int i = 0; i < 4; i++) send_item(rand64(), 4'd8, 1'b0);
      // key change inside a message applies from the next block on
      wait_drained();
      write_reg(REG_KEY1, '1);
      csr_we <= 1'b0;
      for (int i = 0; i < 4; i++) send_item(rand64(), 4'd8, 1'b0);
      send_item(rand64(), 4'd4, 1'b1);

      // random phases, each under a new register setting
      for (int p = 0; p < 10; p++) begin
         wait_drained();
         if (p == 0)
            load_setting('1, '1, '1, '1, '1, '1, '1);
         else
            load_setting(pick_word(), pick_word(), pick_word(), pick_word(), pick_word(),
                         {$urandom, pick_counter()}, {$urandom, pick_counter()});
         idle_pct = (p == 3) ? 0 : 10;
         run_items(58);
      end

      wait_drained();
      repeat (100) @(posedge clock);
      if (sb.errors == 0 && sb.cipher_q.size() == 0)
         $display("TB_OK");
      else
         $display("TB_ERROR");
      $finish;
   end

endmodule
